[src/u8seg_pkg.sv]
// utf8 glyph segmenter package: state encoding, utf-8 range constants
// and the glyph length decoder shared by the segmenter sequencer
// no dependencies
`timescale 1ns / 1ps

package u8seg_pkg;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_RUN  = 3'b010,
		ST_EMIT = 3'b100
	} seg_state_t;

	typedef logic [3:0][7:0] win_t;

	localparam logic [7:0] ASCII_HI  = 8'h7F;
	localparam logic [7:0] LEAD2_LO  = 8'hC2;
	localparam logic [7:0] LEAD2_HI  = 8'hDF;
	localparam logic [7:0] LEAD_E0   = 8'hE0;
	localparam logic [7:0] LEAD_E1   = 8'hE1;
	localparam logic [7:0] LEAD_ED   = 8'hED;
	localparam logic [7:0] LEAD_EF   = 8'hEF;
	localparam logic [7:0] LEAD_F0   = 8'hF0;
	localparam logic [7:0] LEAD_F1   = 8'hF1;
	localparam logic [7:0] LEAD_F3   = 8'hF3;
	localparam logic [7:0] LEAD_F4   = 8'hF4;
	localparam logic [7:0] E0_LO2    = 8'hA0;
	localparam logic [7:0] ED_HI2    = 8'h9F;
	localparam logic [7:0] F0_LO2    = 8'h90;
	localparam logic [7:0] F4_HI2    = 8'h8F;
	localparam logic [7:0] CONT_LO   = 8'h80;
	localparam logic [7:0] CONT_HI   = 8'hBF;

	// length of the glyph at the front of the window, 0 if more bytes are needed
	function automatic logic [2:0] glyph_len(input win_t win, input logic [2:0] n,
			input logic at_end);
		logic [2:0] need;
		logic [7:0] lo2;
		logic [7:0] hi2;
		logic [7:0] lo;
		logic [7:0] hi;
		logic       bad;
		logic [2:0] len;
		begin
			need = 3'd1;
			lo2  = CONT_LO;
			hi2  = CONT_HI;
			bad  = 1'b0;
			case (win[0]) inside
				[8'h00:ASCII_HI]:   need = 3'd1;
				[LEAD2_LO:LEAD2_HI]: need = 3'd2;
				LEAD_E0: begin
					need = 3'd3;
					lo2  = E0_LO2;
				end
				LEAD_ED: begin
					need = 3'd3;
					hi2  = ED_HI2;
				end
				[LEAD_E1:LEAD_EF]:  need = 3'd3;
				LEAD_F0: begin
					need = 3'd4;
					lo2  = F0_LO2;
				end
				LEAD_F4: begin
					need = 3'd4;
					hi2  = F4_HI2;
				end
				[LEAD_F1:LEAD_F3]:  need = 3'd4;
				default:            need = 3'd1;
			endcase
			for (int i = 1; i < 4; i++) begin
				lo = (i == 1) ? lo2 : CONT_LO;
				hi = (i == 1) ? hi2 : CONT_HI;
				if ((3'(i) < n) && (3'(i) < need) && ((win[i] < lo) || (win[i] > hi)))
					bad = 1'b1;
			end
			if (need == 3'd1 || bad)
				len = 3'd1;
			else if (n >= need)
				len = need;
			else
				len = at_end ? 3'd1 : 3'd0;
			return len;
		end
	endfunction

endpackage

[src/utf8_glyph_segmenter_unit.sv]
// utf8 glyph segmenter top level: sequencer, pending byte window and counters
// depends on u8seg_pkg
//
// usage: a string enters one byte per input transaction (data_byte, byte_present,
// is_last) over in_valid/in_ready. an item with byte_present=0 and is_last=0 is
// taken and ignored; byte_present=0 with is_last=1 ends the string without a byte.
// one output transaction (glyph_count, last_glyph_start, overflow) follows each
// item with is_last=1, over out_valid/out_ready.
// timing: an accepted byte is appended to a window of up to four bytes; a shared
// glyph length decoder and saturating adder then resolve one glyph per cycle.
// an item passes from the idle state to the run state, which resolves its glyphs
// (0 to 4); the final item then passes through the emit state to load the result
// register. in_ready is low while an item is being worked on.
// stall: the result register holds until out_ready; a final item waits in the
// emit state while an earlier result is still pending.
// reset: arst_n clears the sequencer, counters and pending count; no clearing pass.
// counters saturate at 2**COUNT_BITS-1 and set overflow; outputs are their low bits.
`timescale 1ns / 1ps

module utf8_glyph_segmenter_unit #(
	parameter int COUNT_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  data_byte,
	input  logic        byte_present,
	input  logic        is_last,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [15:0] glyph_count,
	output logic [15:0] last_glyph_start,
	output logic        overflow
);
	import u8seg_pkg::*;

	localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

	seg_state_t            state_q;
	win_t                  win_q;
	logic [2:0]            n_q;
	logic                  last_q;
	logic [COUNT_BITS-1:0] off_q;
	logic [COUNT_BITS-1:0] glyphs_q;
	logic [COUNT_BITS-1:0] prev_q;
	logic                  ovf_q;
	logic                  out_valid_q;
	logic [15:0]           glyph_count_q;
	logic [15:0]           last_start_q;
	logic                  overflow_q;

	logic                  accept;
	logic                  take_byte;
	logic [2:0]            len;
	logic                  run_done;
	logic                  do_commit;
	logic                  do_emit;
	logic [COUNT_BITS:0]   off_next;
	logic                  off_sat;
	logic                  glyph_sat;
	logic [3:0]            src_idx [4];

	assign in_ready  = (state_q == ST_IDLE);
	assign accept    = in_valid && in_ready;
	assign take_byte = accept && byte_present;
	assign len       = glyph_len(win_q, n_q, last_q);
	assign run_done  = (n_q == 3'd0) || (len == 3'd0);
	assign do_commit = (state_q == ST_RUN) && !run_done;
	assign do_emit   = (state_q == ST_EMIT) && (!out_valid_q || out_ready);
	assign off_next  = {1'b0, off_q} + (COUNT_BITS+1)'(len);
	assign off_sat   = off_next > {1'b0, CNT_MAX};
	assign glyph_sat = (glyphs_q == CNT_MAX);

	always_comb begin
		for (int k = 0; k < 4; k++)
			src_idx[k] = 4'(k) + 4'(len);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			n_q         <= 3'd0;
			last_q      <= 1'b0;
			off_q       <= '0;
			glyphs_q    <= '0;
			prev_q      <= '0;
			ovf_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (do_emit)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accept && (byte_present || is_last)) begin
						last_q  <= is_last;
						state_q <= ST_RUN;
						if (byte_present)
							n_q <= n_q + 3'd1;
					end
				end
				ST_RUN: begin
					if (run_done) begin
						state_q <= last_q ? ST_EMIT : ST_IDLE;
					end else begin
						prev_q <= off_q;
						n_q    <= n_q - len;
						if (glyph_sat || off_sat)
							ovf_q <= 1'b1;
						if (!glyph_sat)
							glyphs_q <= glyphs_q + COUNT_BITS'(1);
						if (off_sat)
							off_q <= CNT_MAX;
						else
							off_q <= off_next[COUNT_BITS-1:0];
					end
				end
				ST_EMIT: begin
					if (do_emit) begin
						n_q         <= 3'd0;
						last_q      <= 1'b0;
						off_q       <= '0;
						glyphs_q    <= '0;
						prev_q      <= '0;
						ovf_q       <= 1'b0;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// window bytes and result payload
	always_ff @(posedge clk) begin
		if (take_byte)
			win_q[n_q[1:0]] <= data_byte;
		if (do_commit) begin
			for (int k = 0; k < 4; k++) begin
				if (src_idx[k] < 4'd4)
					win_q[k] <= win_q[src_idx[k][1:0]];
			end
		end
		if (do_emit) begin
			glyph_count_q <= 16'(glyphs_q);
			last_start_q  <= 16'(prev_q);
			overflow_q    <= ovf_q;
		end
	end

	assign out_valid        = out_valid_q;
	assign glyph_count      = glyph_count_q;
	assign last_glyph_start = last_start_q;
	assign overflow         = overflow_q;

	a_busy_not_ready: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> !in_ready)
		else $error("input taken while sequencer busy");

	a_window_bound: assert property (@(posedge clk) disable iff (!arst_n)
		n_q <= 3'd4)
		else $error("window count out of range");

	a_idle_pending: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> (n_q <= 3'd3))
		else $error("more than three bytes pending between items");

	a_emit_clears: assert property (@(posedge clk) disable iff (!arst_n)
		do_emit |=> (glyphs_q == '0) && (n_q == 3'd0) && out_valid_q)
		else $error("string state not cleared after result");

endmodule

[dv/utf8_glyph_segmenter_checker.sv]
// checker for the utf8 glyph segmenter: watches both transaction channels, predicts
// the tally of each string and compares it with the result transaction
// depends on u8seg_pkg
`timescale 1ns / 1ps

module utf8_glyph_segmenter_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic [7:0]  data_byte,
	input  logic        byte_present,
	input  logic        is_last,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [15:0] glyph_count,
	input  logic [15:0] last_glyph_start,
	input  logic        overflow,
	output int          mismatches,
	output int          tallies_due
);
	import u8seg_pkg::*;

	localparam logic [15:0] SAT = 16'hFFFF;

	typedef struct packed {
		logic [15:0] glyphs;
		logic [15:0] start;
		logic        ovf;
	} tally_t;

	tally_t      tally_q[$];
	tally_t      want;
	logic [7:0]  held [3];
	int          held_n;
	logic [7:0]  win [4];
	int          win_n;
	logic [15:0] next_off;
	logic [15:0] glyph_tot;
	logic [15:0] prev_off;
	logic        sat_seen;

	task automatic report_mismatch(input string msg);
		if (mismatches < 50)
			$display("mismatch at %0t ns: %s", $time, msg);
		mismatches++;
	endtask

	task automatic clear_string();
		held_n    = 0;
		next_off  = '0;
		glyph_tot = '0;
		prev_off  = '0;
		sat_seen  = 1'b0;
	endtask

	// bytes taken by the glyph at the front of the window, 0 while it is still open
	function automatic int front_len(input bit at_end);
		int         need;
		logic [7:0] lo2;
		logic [7:0] hi2;
		need = 1;
		lo2  = CONT_LO;
		hi2  = CONT_HI;
		if (win[0] >= LEAD2_LO && win[0] <= LEAD2_HI)
			need = 2;
		else if (win[0] >= LEAD_E0 && win[0] <= LEAD_EF)
			need = 3;
		else if (win[0] >= LEAD_F0 && win[0] <= LEAD_F4)
			need = 4;
		if (win[0] == LEAD_E0)
			lo2 = E0_LO2;
		if (win[0] == LEAD_ED)
			hi2 = ED_HI2;
		if (win[0] == LEAD_F0)
			lo2 = F0_LO2;
		if (win[0] == LEAD_F4)
			hi2 = F4_HI2;
		if (need == 1)
			return 1;
		if (win_n > 1 && (win[1] < lo2 || win[1] > hi2))
			return 1;
		for (int k = 2; k < need && k < win_n; k++)
			if (win[k] < CONT_LO || win[k] > CONT_HI)
				return 1;
		if (win_n >= need)
			return need;
		return at_end ? 1 : 0;
	endfunction

	task automatic close_glyph(input int len);
		logic [16:0] sum;
		prev_off = next_off;
		if (glyph_tot != SAT)
			glyph_tot = glyph_tot + 16'd1;
		else
			sat_seen = 1'b1;
		sum = {1'b0, next_off} + 17'(len);
		if (sum > {1'b0, SAT}) begin
			next_off = SAT;
			sat_seen = 1'b1;
		end else begin
			next_off = sum[15:0];
		end
	endtask

	task automatic segment_byte(input logic [7:0] value, input logic present,
			input logic closing);
		int     len;
		tally_t t;
		if (!present && !closing)
			return;
		win_n = held_n;
		for (int k = 0; k < held_n; k++)
			win[k] = held[k];
		if (present) begin
			win[win_n] = value;
			win_n++;
		end
		while (win_n > 0) begin
			len = front_len(closing);
			if (len == 0)
				break;
			close_glyph(len);
			for (int k = 0; k + len < win_n; k++)
				win[k] = win[k + len];
			win_n -= len;
		end
		for (int k = 0; k < win_n; k++)
			held[k] = win[k];
		held_n = win_n;
		if (closing) begin
			t.glyphs = glyph_tot;
			t.start  = prev_off;
			t.ovf    = sat_seen;
			tally_q.push_back(t);
			clear_string();
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_string();
			tally_q.delete();
			mismatches  = 0;
			tallies_due = 0;
		end else begin
			if (in_valid && in_ready)
				segment_byte(data_byte, byte_present, is_last);
			if (out_valid && out_ready) begin
				if (tally_q.size() == 0) begin
					report_mismatch($sformatf("result %0d/%0d/%0d with no string pending",
						glyph_count, last_glyph_start, overflow));
				end else begin
					want = tally_q.pop_front();
					if (glyph_count !== want.glyphs)
						report_mismatch($sformatf("glyph_count %0d, expected %0d",
							glyph_count, want.glyphs));
					if (last_glyph_start !== want.start)
						report_mismatch($sformatf("last_glyph_start %0d, expected %0d",
							last_glyph_start, want.start));
					if (overflow !== want.ovf)
						report_mismatch($sformatf("overflow %0b, expected %0b",
							overflow, want.ovf));
				end
			end
			tallies_due = tally_q.size();
		end
	end

endmodule

[dv/tb_utf8_glyph_segmenter_unit.sv]
// testbench top for utf8_glyph_segmenter_unit: drives strings of well-formed and
// broken utf-8 with random idling on both channels and gives the verdict
// depends on u8seg_pkg, utf8_glyph_segmenter_unit and utf8_glyph_segmenter_checker
`timescale 1ns / 1ps

module tb_utf8_glyph_segmenter_unit;
	import u8seg_pkg::*;

	localparam int unsigned CYCLE_LIMIT  = 3_000_000;
	localparam int          RANDOM_ITEMS = 1550;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [7:0]  data_byte;
	logic        byte_present;
	logic        is_last;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [15:0] glyph_count;
	logic [15:0] last_glyph_start;
	logic        overflow;
	int          mismatches;
	int          tallies_due;

	int unsigned cycles = 0;
	int unsigned ready_hold = 0;
	int          ready_roll;
	bit          calm;
	int          sent;
	int          units;
	logic [7:0]  text_q[$];

	utf8_glyph_segmenter_unit dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_ready         (in_ready),
		.data_byte        (data_byte),
		.byte_present     (byte_present),
		.is_last          (is_last),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.glyph_count      (glyph_count),
		.last_glyph_start (last_glyph_start),
		.overflow         (overflow)
	);

	utf8_glyph_segmenter_checker checker_i (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_ready         (in_ready),
		.data_byte        (data_byte),
		.byte_present     (byte_present),
		.is_last          (is_last),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.glyph_count      (glyph_count),
		.last_glyph_start (last_glyph_start),
		.overflow         (overflow),
		.mismatches       (mismatches),
		.tallies_due      (tallies_due)
	);

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	// result side stalls
	always @(negedge clk) begin
		if (ready_hold != 0) begin
			ready_hold <= ready_hold - 1;
		end else begin
			ready_roll = $urandom_range(0, 99);
			if (ready_roll < 60) begin
				out_ready  <= 1'b1;
				ready_hold <= $urandom_range(0, 15);
			end else if (ready_roll < 92) begin
				out_ready  <= 1'b0;
				ready_hold <= $urandom_range(0, 3);
			end else begin
				out_ready  <= 1'b0;
				ready_hold <= $urandom_range(10, 50);
			end
		end
	end

	function automatic int gap_len();
		int roll;
		if (calm)
			return 0;
		roll = $urandom_range(0, 99);
		if (roll < 50)
			return 0;
		if (roll < 85)
			return $urandom_range(1, 3);
		if (roll < 97)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [7:0] second_lo(input logic [7:0] lead);
		if (lead == LEAD_E0)
			return E0_LO2;
		if (lead == LEAD_F0)
			return F0_LO2;
		return CONT_LO;
	endfunction

	function automatic logic [7:0] second_hi(input logic [7:0] lead);
		if (lead == LEAD_ED)
			return ED_HI2;
		if (lead == LEAD_F4)
			return F4_HI2;
		return CONT_HI;
	endfunction

	// called at a falling edge, returns at the falling edge after the transaction
	task automatic push_item(input logic [7:0] value, input logic present,
			input logic closing);
		int gap;
		gap = gap_len();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid     <= 1'b1;
		data_byte    <= value;
		byte_present <= present;
		is_last      <= closing;
		do
			@(posedge clk);
		while (!in_ready);
		@(negedge clk);
	endtask

	// one glyph of a given length, possibly cut short or with a bad second byte
	task automatic add_run(input int need, input int keep, input bit spoil);
		logic [7:0] seq [4];
		logic [7:0] lo;
		logic [7:0] hi;
		int         roll;
		case (need)
			1: seq[0] = 8'($urandom_range(0, ASCII_HI));
			2: seq[0] = 8'($urandom_range(LEAD2_LO, LEAD2_HI));
			3: begin
				if ($urandom_range(0, 2) == 0)
					seq[0] = ($urandom_range(0, 1) == 0) ? LEAD_E0 : LEAD_ED;
				else
					seq[0] = 8'($urandom_range(LEAD_E0, LEAD_EF));
			end
			default: begin
				if ($urandom_range(0, 2) == 0)
					seq[0] = ($urandom_range(0, 1) == 0) ? LEAD_F0 : LEAD_F4;
				else
					seq[0] = 8'($urandom_range(LEAD_F0, LEAD_F4));
			end
		endcase
		for (int k = 1; k < need; k++) begin
			lo   = (k == 1) ? second_lo(seq[0]) : CONT_LO;
			hi   = (k == 1) ? second_hi(seq[0]) : CONT_HI;
			roll = $urandom_range(0, 7);
			if (spoil && k == 1) begin
				if (roll < 4)
					seq[k] = 8'($urandom_range(0, lo - 8'd1));
				else
					seq[k] = 8'($urandom_range(hi + 8'd1, 8'hFF));
			end else if (roll == 0) begin
				seq[k] = lo;
			end else if (roll == 1) begin
				seq[k] = hi;
			end else begin
				seq[k] = 8'($urandom_range(lo, hi));
			end
		end
		for (int k = 0; k < keep; k++)
			text_q.push_back(seq[k]);
	endtask

	task automatic add_unit();
		int roll;
		int need;
		roll = $urandom_range(0, 99);
		need = $urandom_range(1, 4);
		if (roll < 65) begin
			add_run(need, need, 1'b0);
		end else if (roll < 80) begin
			need = $urandom_range(2, 4);
			add_run(need, $urandom_range(1, need - 1), 1'b0);
		end else if (roll < 92) begin
			need = $urandom_range(2, 4);
			add_run(need, $urandom_range(2, need), 1'b1);
		end else begin
			text_q.push_back(8'($urandom));
		end
	endtask

	task automatic send_text(input bit use_marker);
		int idx;
		for (idx = 0; idx < text_q.size(); idx++) begin
			if (!calm && $urandom_range(0, 19) == 0)
				push_item(8'($urandom), 1'b0, 1'b0);
			push_item(text_q[idx], 1'b1, !use_marker && idx == text_q.size() - 1);
			sent++;
		end
		if (use_marker || text_q.size() == 0) begin
			push_item(8'($urandom), 1'b0, 1'b1);
			sent++;
		end
		text_q.delete();
	endtask

	initial begin
		in_valid     = 1'b0;
		data_byte    = 8'h00;
		byte_present = 1'b0;
		is_last      = 1'b0;
		arst_n       = 1'b0;
		calm         = 1'b0;
		sent         = 0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// empty string, then an ignored transaction ahead of a two byte string
		push_item(8'h00, 1'b0, 1'b1);
		push_item(8'hFF, 1'b0, 1'b0);
		push_item(8'h00, 1'b1, 1'b0);
		push_item(8'hFF, 1'b1, 1'b1);
		// narrowed second byte ranges, ending in a sequence cut short
		push_item(LEAD_E0, 1'b1, 1'b0);
		push_item(E0_LO2, 1'b1, 1'b0);
		push_item(CONT_LO, 1'b1, 1'b0);
		push_item(LEAD_ED, 1'b1, 1'b0);
		push_item(8'hA0, 1'b1, 1'b0);
		push_item(LEAD_F0, 1'b1, 1'b0);
		push_item(8'h8F, 1'b1, 1'b0);
		push_item(LEAD_F4, 1'b1, 1'b0);
		push_item(F4_HI2, 1'b1, 1'b0);
		push_item(CONT_HI, 1'b1, 1'b1);
		// overlong lead, bad continuation, then a full four byte glyph and a terminator
		push_item(8'hC1, 1'b1, 1'b0);
		push_item(LEAD2_LO, 1'b1, 1'b0);
		push_item(ASCII_HI, 1'b1, 1'b0);
		push_item(LEAD2_HI, 1'b1, 1'b0);
		push_item(CONT_HI, 1'b1, 1'b0);
		push_item(LEAD_F0, 1'b1, 1'b0);
		push_item(F0_LO2, 1'b1, 1'b0);
		push_item(CONT_LO, 1'b1, 1'b0);
		push_item(CONT_LO, 1'b1, 1'b0);
		push_item(8'h5A, 1'b0, 1'b1);

		while (sent < RANDOM_ITEMS) begin
			calm = ($urandom_range(0, 9) == 0);
			if ($urandom_range(0, 9) == 0)
				units = $urandom_range(0, 30);
			else
				units = $urandom_range(0, 6);
			repeat (units) add_unit();
			send_text($urandom_range(0, 3) == 0);
		end

		in_valid <= 1'b0;
		while (tallies_due != 0)
			@(negedge clk);
		repeat (20) @(negedge clk);
		if (mismatches == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
